>>> rtl/thrm_pkg.sv
// Shared widths and constants for the thermistor thermostat.
package thrm_pkg;

  localparam int ADC_BITS = 12;
  localparam longint ADC_FULL = (64'd1 << ADC_BITS) - 1;

  localparam int DIFF_W = $clog2(11 * ADC_FULL + 1);
  localparam int NUM_W  = $clog2(10000 * 11 * ADC_FULL + 1);
  localparam int DVD_W  = NUM_W + 16;
  localparam int Q_W    = (DVD_W > 48) ? DVD_W : 48;
  localparam int DS_W   = 40;
  localparam int CNT_W  = $clog2(Q_W);
  localparam int E_W    = $clog2(Q_W);
  localparam int LG_W   = E_W + 30;
  localparam int L_W    = 29;
  localparam int L2_W   = 34;
  localparam int L3_W   = 30;
  localparam int OP_W   = 33;
  localparam int P_W    = 2 * OP_W;

  localparam logic [27:0] LN2_Q28 = 28'd186065279;
  localparam logic [Q_W-1:0] RCP_NUM = Q_W'(100) << 40;
  localparam logic [Q_W-1:0] Q_HI = Q_W'(15000 + 27310);
  localparam logic [Q_W-1:0] Q_LO = Q_W'(27310 - 5500);
  localparam logic [Q_W-1:0] T_OFFSET = Q_W'(27310);
  localparam logic signed [14:0] T_MAX = 15'sd15000;
  localparam logic signed [14:0] T_MIN = -15'sd5500;

  localparam logic [2:0] REG_COEFF_A = 3'd0;
  localparam logic [2:0] REG_COEFF_B = 3'd1;
  localparam logic [2:0] REG_COEFF_C = 3'd2;
  localparam logic [2:0] REG_SETPOINT = 3'd3;
  localparam logic [2:0] REG_BAND = 3'd4;
  localparam logic [2:0] REG_PERIOD = 3'd5;

  typedef logic [4:0] state_t;

endpackage

>>> rtl/thermistor_thermostat.sv
// Thermistor thermostat: Steinhart-Hart temperature, hysteresis heater control, publish flag.
//
// When the Steinhart-Hart sum is zero or negative, the reciprocal division is skipped. A sample
// runs through the shared restoring divider, one quotient bit per cycle, run twice (resistance
// and reciprocal), and through the shared 33x33 multiplier, which does the 30 squaring passes
// of the logarithm and the later products. in_ready is high only while idle. A finished result
// waits in the output register, and the next transaction can be taken meanwhile. The last step
// of a sample holds while the previous result is still waiting for out_ready.
// Configuration registers sit at byte addresses 0, 4, ... 20 in list order.
module thermistor_thermostat import thrm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ADC_BITS-1:0]        in_adc_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [14:0]         out_temperature,
  output logic                       out_clamped,
  output logic                       out_heater_on,
  output logic                       out_heater_report,
  output logic                       out_hot_led,
  output logic                       out_cold_led,
  output logic                       out_publish_temp,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [4:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  localparam state_t S_IDLE = 5'd0;
  localparam state_t S_DIV  = 5'd1;
  localparam state_t S_NORM = 5'd2;
  localparam state_t S_LSQ  = 5'd3;
  localparam state_t S_LADJ = 5'd4;
  localparam state_t S_LN1  = 5'd5;
  localparam state_t S_LN2  = 5'd6;
  localparam state_t S_LN3  = 5'd7;
  localparam state_t S_L2   = 5'd8;
  localparam state_t S_L2T  = 5'd9;
  localparam state_t S_L3H  = 5'd10;
  localparam state_t S_L3L  = 5'd11;
  localparam state_t S_L3T  = 5'd12;
  localparam state_t S_YB   = 5'd13;
  localparam state_t S_YC   = 5'd14;
  localparam state_t S_YS   = 5'd15;
  localparam state_t S_RCP  = 5'd16;
  localparam state_t S_DONE = 5'd17;

  state_t state_r, state_nxt;
  logic [31:0] coeff_a_r, coeff_b_r, coeff_c_r;
  logic signed [14:0] setpoint_r;
  logic [9:0] band_r;
  logic [15:0] period_r;
  logic heater_r, heater_nxt;
  logic [16:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;
  logic div_sel_r, div_sel_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [Q_W-1:0] quo_r, quo_nxt;
  logic [DS_W-1:0] rem_r, rem_nxt;
  logic [DS_W-1:0] den_r, den_nxt;
  logic [E_W-1:0] e_r, e_nxt;
  logic [30:0] m_r, m_nxt;
  logic [29:0] frac_r, frac_nxt;
  logic [L_W-1:0] l_r, l_nxt;
  logic [L2_W-1:0] l2_r, l2_nxt;
  logic [L3_W-1:0] l3_r, l3_nxt;
  logic signed [P_W-1:0] acc_r, acc_nxt;
  logic signed [P_W-1:0] p_r;
  logic signed [14:0] t_r, t_nxt;
  logic clamp_r, clamp_nxt;
  logic signed [14:0] otemp_r, otemp_nxt;
  logic [5:0] oflags_r, oflags_nxt;

  logic signed [OP_W-1:0] op_a, op_b;
  logic [ADC_BITS-1:0] s_eff;
  logic [DIFF_W-1:0] diff;
  logic [NUM_W-1:0] num;
  logic [DS_W:0] trial;
  logic take;
  logic [31:0] sq;
  logic [LG_W-1:0] lg;
  logic signed [P_W-1:0] sum;
  logic signed [P_W-1:0] y_sum;
  logic signed [16:0] thr_hi, thr_lo;
  logic hot, cold, pub;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_COEFF_A:  cfg_prdata = coeff_a_r;
      REG_COEFF_B:  cfg_prdata = coeff_b_r;
      REG_COEFF_C:  cfg_prdata = coeff_c_r;
      REG_SETPOINT: cfg_prdata = 32'(setpoint_r);
      REG_BAND:     cfg_prdata = 32'(band_r);
      REG_PERIOD:   cfg_prdata = 32'(period_r);
      default:      cfg_prdata = 32'd0;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_temperature = otemp_r;
  assign {out_clamped, out_heater_on, out_heater_report, out_hot_led, out_cold_led,
          out_publish_temp} = oflags_r;

  assign s_eff = (in_adc_sample == '0) ? ADC_BITS'(1) : in_adc_sample;
  assign diff = DIFF_W'(11 * ADC_FULL) - (DIFF_W'(s_eff) << 3);
  assign num = NUM_W'(diff) * NUM_W'(10000);
  assign trial = {rem_r, quo_r[Q_W-1]};
  assign take = (trial >= {1'b0, den_r});
  assign sq = p_r[61:30];
  assign lg = {e_r - E_W'(16), frac_r};
  assign sum = acc_r + p_r;
  assign y_sum = acc_r + (p_r >>> 28);
  assign thr_hi = 17'(setpoint_r) + 17'(signed'({1'b0, band_r}));
  assign thr_lo = 17'(setpoint_r) - 17'(signed'({1'b0, band_r}));
  assign hot = 17'(t_r) > thr_hi;
  assign cold = 17'(t_r) < thr_lo;
  assign pub = count_r > {1'b0, period_r};

  always_comb begin
    unique case (state_r)
      S_LSQ: begin
        op_a = OP_W'(m_r);
        op_b = OP_W'(m_r);
      end
      S_LN1: begin
        op_a = OP_W'(lg[LG_W-1:18]);
        op_b = OP_W'(LN2_Q28);
      end
      S_LN2: begin
        op_a = OP_W'(lg[17:0]);
        op_b = OP_W'(LN2_Q28);
      end
      S_L2: begin
        op_a = OP_W'(l_r);
        op_b = OP_W'(l_r);
      end
      S_L3H: begin
        op_a = OP_W'(l2_r[L2_W-1:18]);
        op_b = OP_W'(l_r);
      end
      S_L3L: begin
        op_a = OP_W'(l2_r[17:0]);
        op_b = OP_W'(l_r);
      end
      S_YB: begin
        op_a = OP_W'(signed'(coeff_b_r));
        op_b = OP_W'(l_r);
      end
      S_YC: begin
        op_a = OP_W'(signed'(coeff_c_r));
        op_b = OP_W'(l3_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    heater_nxt = heater_r;
    count_nxt = count_r;
    out_valid_nxt = out_valid_r;
    div_sel_nxt = div_sel_r;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    e_nxt = e_r;
    m_nxt = m_r;
    frac_nxt = frac_r;
    l_nxt = l_r;
    l2_nxt = l2_r;
    l3_nxt = l3_r;
    acc_nxt = acc_r;
    t_nxt = t_r;
    clamp_nxt = clamp_r;
    otemp_nxt = otemp_r;
    oflags_nxt = oflags_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          quo_nxt = Q_W'(num) << 16;
          rem_nxt = '0;
          den_nxt = DS_W'(s_eff) << 3;
          cnt_nxt = '0;
          div_sel_nxt = 1'b0;
          e_nxt = E_W'(Q_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = take ? DS_W'(trial - {1'b0, den_r}) : trial[DS_W-1:0];
        quo_nxt = {quo_r[Q_W-2:0], take};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          state_nxt = div_sel_r ? S_RCP : S_NORM;
        end
      end
      S_NORM: begin
        if (quo_r[Q_W-1]) begin
          m_nxt = quo_r[Q_W-1 -: 31];
          cnt_nxt = CNT_W'(29);
          state_nxt = S_LSQ;
        end else begin
          quo_nxt = quo_r << 1;
          e_nxt = e_r - 1'b1;
        end
      end
      S_LSQ: state_nxt = S_LADJ;
      S_LADJ: begin
        m_nxt = sq[31] ? sq[31:1] : sq[30:0];
        frac_nxt = {frac_r[28:0], sq[31]};
        cnt_nxt = cnt_r - 1'b1;
        state_nxt = (cnt_r == '0) ? S_LN1 : S_LSQ;
      end
      S_LN1: state_nxt = S_LN2;
      S_LN2: begin
        acc_nxt = p_r <<< 18;
        state_nxt = S_LN3;
      end
      S_LN3: begin
        l_nxt = sum[34 +: L_W];
        state_nxt = S_L2;
      end
      S_L2: state_nxt = S_L2T;
      S_L2T: begin
        l2_nxt = p_r[24 +: L2_W];
        state_nxt = S_L3H;
      end
      S_L3H: state_nxt = S_L3L;
      S_L3L: begin
        acc_nxt = p_r <<< 18;
        state_nxt = S_L3T;
      end
      S_L3T: begin
        l3_nxt = sum[32 +: L3_W];
        state_nxt = S_YB;
      end
      S_YB: state_nxt = S_YC;
      S_YC: begin
        acc_nxt = P_W'(signed'(coeff_a_r)) + (p_r >>> 24);
        state_nxt = S_YS;
      end
      S_YS: begin
        if (y_sum == '0) begin
          t_nxt = T_MAX;
          clamp_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (y_sum[P_W-1]) begin
          t_nxt = T_MIN;
          clamp_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          quo_nxt = RCP_NUM + Q_W'(y_sum[DS_W-1:1]);
          rem_nxt = '0;
          den_nxt = y_sum[DS_W-1:0];
          cnt_nxt = '0;
          div_sel_nxt = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_RCP: begin
        if (quo_r > Q_HI) begin
          t_nxt = T_MAX;
          clamp_nxt = 1'b1;
        end else if (quo_r < Q_LO) begin
          t_nxt = T_MIN;
          clamp_nxt = 1'b1;
        end else begin
          t_nxt = 15'(quo_r - T_OFFSET);
          clamp_nxt = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          if (hot) begin
            heater_nxt = 1'b0;
          end else if (cold) begin
            heater_nxt = 1'b1;
          end
          count_nxt = pub ? 17'd0 : count_r + 17'd1;
          otemp_nxt = t_r;
          oflags_nxt = {clamp_r, hot ? 1'b0 : (cold ? 1'b1 : heater_r), hot | cold,
                        hot, cold, pub};
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      heater_r <= 1'b0;
      count_r <= '0;
      out_valid_r <= 1'b0;
      div_sel_r <= 1'b0;
      coeff_a_r <= 32'd1109681585;
      coeff_b_r <= 32'd261508426;
      coeff_c_r <= 32'd909368000;
      setpoint_r <= 15'sd2000;
      band_r <= 10'd100;
      period_r <= 16'd10;
    end else begin
      state_r <= state_nxt;
      heater_r <= heater_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
      div_sel_r <= div_sel_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          REG_COEFF_A:  coeff_a_r <= cfg_pwdata;
          REG_COEFF_B:  coeff_b_r <= cfg_pwdata;
          REG_COEFF_C:  coeff_c_r <= cfg_pwdata;
          REG_SETPOINT: setpoint_r <= cfg_pwdata[14:0];
          REG_BAND:     band_r <= cfg_pwdata[9:0];
          REG_PERIOD:   period_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    e_r <= e_nxt;
    m_r <= m_nxt;
    frac_r <= frac_nxt;
    l_r <= l_nxt;
    l2_r <= l2_nxt;
    l3_r <= l3_nxt;
    acc_r <= acc_nxt;
    p_r <= op_a * op_b;
    t_r <= t_nxt;
    clamp_r <= clamp_nxt;
    otemp_r <= otemp_nxt;
    oflags_r <= oflags_nxt;
  end

endmodule

>>> bench/thermistor_thermostat_chk.sv
// Checker for the thermistor thermostat: watches both channels and config writes, predicts, compares.
module thermistor_thermostat_chk import thrm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [ADC_BITS-1:0] in_adc_sample,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [14:0]  out_temperature,
  input  logic                out_clamped,
  input  logic                out_heater_on,
  input  logic                out_heater_report,
  input  logic                out_hot_led,
  input  logic                out_cold_led,
  input  logic                out_publish_temp,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic                cfg_pready,
  output int                  errors,
  output int                  pending
);

  typedef struct {
    logic signed [14:0] temperature;
    logic clamped;
    logic heater_on;
    logic heater_report;
    logic hot_led;
    logic cold_led;
    logic publish_temp;
  } reading_t;

  reading_t reading_q[$];

  longint coef_a, coef_b, coef_c, setpoint_c, band_c;
  longint unsigned period_c;
  logic heater;
  logic [16:0] sample_cnt;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic longint unsigned log2_q30(input longint unsigned x);
    int e;
    longint unsigned m, frac;
    e = 63;
    frac = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'd1 << i);
      end
    end
    return (longint'(e - 16) << 30) + frac;
  endfunction

  function automatic reading_t convert_sample(input logic [ADC_BITS-1:0] raw);
    reading_t r;
    longint unsigned s, num, den, ohms, lg, ln_r, ln_sq, ln_cu, quo;
    longint recip, temp;
    s = (raw == 0) ? 1 : raw;
    num = 10000 * (11 * ADC_FULL - 8 * s);
    den = 8 * s;
    ohms = (num << 16) / den;
    lg = log2_q30(ohms);
    ln_r = (lg * LN2_Q28) >> 34;
    ln_sq = (ln_r * ln_r) >> 24;
    ln_cu = (ln_sq * ln_r) >> 32;
    recip = coef_a + ((coef_b * longint'(ln_r)) >>> 24) + ((coef_c * longint'(ln_cu)) >>> 28);
    r.clamped = 1'b0;
    if (recip == 0) begin
      temp = 15000;
      r.clamped = 1'b1;
    end else if (recip < 0) begin
      temp = -5500;
      r.clamped = 1'b1;
    end else begin
      quo = ((64'd100 << 40) + (longint'(recip) >> 1)) / longint'(recip);
      temp = longint'(quo) - 27310;
      if (temp > 15000) begin
        temp = 15000;
        r.clamped = 1'b1;
      end
      if (temp < -5500) begin
        temp = -5500;
        r.clamped = 1'b1;
      end
    end
    r.heater_report = 1'b0;
    r.hot_led = 1'b0;
    r.cold_led = 1'b0;
    if (temp > setpoint_c + band_c) begin
      heater = 1'b0;
      r.hot_led = 1'b1;
      r.heater_report = 1'b1;
    end else if (temp < setpoint_c - band_c) begin
      heater = 1'b1;
      r.cold_led = 1'b1;
      r.heater_report = 1'b1;
    end
    r.publish_temp = 1'b0;
    if (longint'(sample_cnt) > period_c) begin
      r.publish_temp = 1'b1;
      sample_cnt = '0;
    end else begin
      sample_cnt = sample_cnt + 1'b1;
    end
    r.temperature = temp[14:0];
    r.heater_on = heater;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reading_t w;
    if (!rst_n) begin
      coef_a = 1109681585;
      coef_b = 261508426;
      coef_c = 909368000;
      setpoint_c = 2000;
      band_c = 100;
      period_c = 10;
      heater = 1'b0;
      sample_cnt = '0;
      reading_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_COEFF_A: coef_a = longint'(signed'(cfg_pwdata));
          REG_COEFF_B: coef_b = longint'(signed'(cfg_pwdata));
          REG_COEFF_C: coef_c = longint'(signed'(cfg_pwdata));
          REG_SETPOINT: setpoint_c = longint'(signed'(cfg_pwdata[14:0]));
          REG_BAND: band_c = cfg_pwdata[9:0];
          REG_PERIOD: period_c = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          $display("%0t unexpected transaction: expected none actual temperature %0d",
                   $time, out_temperature);
          errors++;
        end else begin
          w = reading_q.pop_front();
          check_field("temperature", w.temperature, out_temperature);
          check_field("clamped", w.clamped, out_clamped);
          check_field("heater_on", w.heater_on, out_heater_on);
          check_field("heater_report", w.heater_report, out_heater_report);
          check_field("hot_led", w.hot_led, out_hot_led);
          check_field("cold_led", w.cold_led, out_cold_led);
          check_field("publish_temp", w.publish_temp, out_publish_temp);
        end
      end
      if (in_valid && in_ready) reading_q.push_back(convert_sample(in_adc_sample));
    end
    pending = reading_q.size();
  end

endmodule

>>> bench/thermistor_thermostat_tb.sv
// Testbench top for the thermistor thermostat: stimulus, config writes and verdict.
module thermistor_thermostat_tb import thrm_pkg::*;;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ADC_BITS-1:0] in_adc_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [14:0] out_temperature;
  logic out_clamped, out_heater_on, out_heater_report;
  logic out_hot_led, out_cold_led, out_publish_temp;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int errors, pending;
  logic [15:0] ready_cyc = '0;

  thermistor_thermostat u_top (.*);

  thermistor_thermostat_chk u_chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    ready_cyc <= ready_cyc + 1'b1;
    case (ready_cyc[11:10])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(1, 0));
      2'd2: out_ready <= (ready_cyc[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(3, 0) != 0);
    endcase
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [ADC_BITS-1:0] s);
    in_valid <= 1'b1;
    in_adc_sample <= s;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic set_defaults();
    cfg_write(REG_COEFF_A, 32'd1109681585);
    cfg_write(REG_COEFF_B, 32'd261508426);
    cfg_write(REG_COEFF_C, 32'd909368000);
  endtask

  function automatic logic [ADC_BITS-1:0] pick_sample();
    if ($urandom_range(9, 0) == 0) begin
      case ($urandom_range(4, 0))
        0: return '0;
        1: return ADC_BITS'(1);
        2: return ADC_BITS'(ADC_FULL);
        3: return ADC_BITS'(ADC_FULL - 1);
        default: return ADC_BITS'(2048);
      endcase
    end
    return ADC_BITS'($urandom_range(ADC_FULL, 0));
  endfunction

  task automatic run_bursts(input int total);
    int burst, gap;
    while (total > 0) begin
      burst = $urandom_range(8, 1);
      for (int i = 0; i < burst && total > 0; i++) begin
        send_sample(pick_sample());
        total--;
      end
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    drain();
  endtask

  initial begin
    int base;
    logic [ADC_BITS-1:0] directed [14];
    directed = '{0, 1, 2, 3, 100, 500, 1000, 1500, 2048, 2500, 3000, 3500, 4094, 4095};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_sample(directed[i]);
    drain();

    cfg_write(REG_COEFF_A, 32'd0);
    cfg_write(REG_COEFF_B, 32'd0);
    cfg_write(REG_COEFF_C, 32'd0);
    send_sample(ADC_BITS'(2048));
    send_sample('0);
    drain();
    cfg_write(REG_COEFF_A, 32'hFFFF_FFFF);
    send_sample(ADC_BITS'(2048));
    drain();
    cfg_write(REG_COEFF_A, 32'h8000_0000);
    send_sample(ADC_BITS'(ADC_FULL));
    drain();
    cfg_write(REG_COEFF_A, 32'h7FFF_FFFF);
    cfg_write(REG_COEFF_B, 32'h7FFF_FFFF);
    cfg_write(REG_COEFF_C, 32'h7FFF_FFFF);
    send_sample(ADC_BITS'(1));
    send_sample(ADC_BITS'(ADC_FULL));
    drain();
    cfg_write(REG_COEFF_A, 32'd1);
    cfg_write(REG_COEFF_B, 32'h8000_0000);
    cfg_write(REG_COEFF_C, 32'h8000_0000);
    send_sample(ADC_BITS'(1));
    send_sample(ADC_BITS'(ADC_FULL));
    drain();
    set_defaults();
    cfg_write(3'd6, 32'hFFFF_FFFF);
    cfg_write(3'd7, 32'h0);
    cfg_write(REG_SETPOINT, 32'(-4000));
    cfg_write(REG_BAND, 32'd0);
    cfg_write(REG_PERIOD, 32'd65535);
    run_bursts(12);
    cfg_write(REG_PERIOD, 32'd3);
    cfg_write(REG_SETPOINT, 32'd12000);
    cfg_write(REG_BAND, 32'd1000);
    run_bursts(10);
    cfg_write(REG_PERIOD, 32'd0);
    run_bursts(6);

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_SETPOINT, 32'($urandom_range(16000, 0)) - 32'd4000);
      cfg_write(REG_BAND, $urandom_range(1000, 0));
      cfg_write(REG_PERIOD, ($urandom_range(5, 0) == 0) ? $urandom_range(65535, 0)
                                                         : $urandom_range(20, 0));
      if (ph % 3 == 2) begin
        base = 1109681585 + $signed($urandom_range(2000000, 0)) - 1000000;
        cfg_write(REG_COEFF_A, base);
        cfg_write(REG_COEFF_B, 32'd261508426 + $urandom_range(400000, 0) - 200000);
        cfg_write(REG_COEFF_C, 32'd909368000 + $urandom_range(4000000, 0) - 2000000);
      end else begin
        set_defaults();
      end
      run_bursts(85);
    end

    if (errors == 0 && pending == 0) begin
      $display("thermistor_thermostat_tb: done, clean");
    end else begin
      $display("thermistor_thermostat_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("thermistor_thermostat_tb: done, errors");
    $finish;
  end

endmodule

>>> files.f
rtl/thrm_pkg.sv
rtl/thermistor_thermostat.sv
bench/thermistor_thermostat_chk.sv
bench/thermistor_thermostat_tb.sv
